// ===== src/flrc_pkg.sv =====
`timescale 1ns / 1ps
// Shared definitions for the clipped fixed-point line rasterizer:
// default widths, configuration register indexes and the microcode table.
// No dependencies.
package flrc_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 16;

	// Configuration port
	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_ENABLE = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_LEFT   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_TOP    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_HEIGHT = 3'd4;

	// Microcode step addresses
	localparam int STEP_BITS = 3;
	typedef logic [STEP_BITS-1:0] step_t;
	localparam step_t STEP_WAIT     = 3'd0;
	localparam step_t STEP_SETUP    = 3'd1;
	localparam step_t STEP_DIV_INIT = 3'd2;
	localparam step_t STEP_DIV_STEP = 3'd3;
	localparam step_t STEP_DIV_END  = 3'd4;

	typedef enum logic [1:0] {
		JC_NEVER    = 2'd0,
		JC_ALWAYS   = 2'd1,
		JC_NO_START = 2'd2,
		JC_DIV_BUSY = 2'd3
	} jump_cond_t;

	typedef struct packed {
		logic       accept;    // take input transfers, run ticks
		logic       setup;     // pick major axis, order endpoints
		logic       div_init;  // load the slope divider
		logic       div_step;  // one restoring division bit
		logic       div_end;   // sign and store the slope
		jump_cond_t jc;
		step_t      target;
	} ctrl_word_t;

	function automatic ctrl_word_t ucode_rom(step_t addr);
		ctrl_word_t cw;
		cw = '{accept: 1'b0, setup: 1'b0, div_init: 1'b0, div_step: 1'b0,
		       div_end: 1'b0, jc: JC_ALWAYS, target: STEP_WAIT};
		case (addr)
			STEP_WAIT: begin
				cw.accept = 1'b1;
				cw.jc     = JC_NO_START;
				cw.target = STEP_WAIT;
			end
			STEP_SETUP: begin
				cw.setup = 1'b1;
				cw.jc    = JC_NEVER;
			end
			STEP_DIV_INIT: begin
				cw.div_init = 1'b1;
				cw.jc       = JC_NEVER;
			end
			STEP_DIV_STEP: begin
				cw.div_step = 1'b1;
				cw.jc       = JC_DIV_BUSY;
				cw.target   = STEP_DIV_STEP;
			end
			STEP_DIV_END: begin
				cw.div_end = 1'b1;
				cw.jc      = JC_ALWAYS;
				cw.target  = STEP_WAIT;
			end
			default: begin
				cw.jc     = JC_ALWAYS;
				cw.target = STEP_WAIT;
			end
		endcase
		return cw;
	endfunction

endpackage

// ===== src/flrc_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the line rasterizer: command input and pixel output.
// Depends on flrc_pkg for the default coordinate width.
interface flrc_in_if #(
	parameter int COORD_BITS = flrc_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic                         mode;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	logic        [31:0]           line_color;

	modport source (output valid, mode, start_x, start_y, end_x, end_y, line_color,
		input ready);
	modport sink (input valid, mode, start_x, start_y, end_x, end_y, line_color,
		output ready);
endinterface

interface flrc_out_if #(
	parameter int COORD_BITS = flrc_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic        [31:0]           pixel_color;
	logic                         write_enable;
	logic                         last_pixel;

	modport source (output valid, pixel_x, pixel_y, pixel_color, write_enable, last_pixel,
		input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_color, write_enable, last_pixel,
		output ready);
endinterface

// ===== src/fixed_point_line_rasterizer_clipped_unit.sv =====
`timescale 1ns / 1ps
// Clipped fixed-point DDA line rasterizer, top level.
// Depends on flrc_pkg and the channel interfaces in flrc_ifs.sv.

// A start transfer (mode 0) loads two endpoints and a color; each tick
// transfer (mode 1) then yields one pixel, with last_pixel set on the final
// one and write_enable cleared for pixels outside the clip rectangle when
// clip_enable is set. A tick with no line in progress is taken and dropped.
// Pixels stream at one per clock while the sink keeps up; the output
// register lets the next tick be taken in the same cycle that the
// previous pixel is transferred out. A start item holds off the input
// after its transfer while the microcode runs one setup step, one divider
// load, one step per quotient bit of the restoring slope divider
// (COORD_BITS + FRAC_BITS bits), and one step to sign the slope. Control
// comes from a five-step microcode table with a step counter and
// conditional jumps. Configuration writes are taken on any cycle and are
// meant to be issued only while no line is being drawn.
module fixed_point_line_rasterizer_clipped_unit #(
	parameter int COORD_BITS = flrc_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = flrc_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [flrc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]             cfg_data,
	flrc_in_if.sink                           in_ch,
	flrc_out_if.source                        out_ch
);
	import flrc_pkg::*;

	localparam int C        = COORD_BITS;
	localparam int F        = FRAC_BITS;
	localparam int POS_BITS = C + F + 1;
	localparam int SLP_BITS = F + 2;
	localparam int DVD_BITS = C + F;
	localparam int CNT_BITS = $clog2(DVD_BITS + 1);

	// Configuration registers
	logic                clip_enable_q;
	logic signed [C-1:0] clip_left_q;
	logic signed [C-1:0] clip_top_q;
	logic        [C-1:0] clip_width_q;
	logic        [C-1:0] clip_height_q;

	// Sequencer
	step_t      step_q, step_d;
	ctrl_word_t cw;
	logic       take_jump;

	// Captured start item
	logic signed [C-1:0] x0_q, y0_q, x1_q, y1_q;

	// Line state
	logic                       line_active_q;
	logic                       major_is_x_q;
	logic signed [C-1:0]        major_pos_q;
	logic signed [C-1:0]        major_end_q;
	logic signed [POS_BITS-1:0] minor_pos_q;
	logic signed [SLP_BITS-1:0] minor_slope_q;
	logic [31:0]                color_q;

	// Slope divider
	logic signed [C:0]   dmin_q;
	logic [C-1:0]        divisor_q;
	logic [C-1:0]        rem_q;
	logic [DVD_BITS-1:0] dvd_q;
	logic [CNT_BITS-1:0] div_cnt_q;

	// Output register
	logic                out_valid_q;
	logic signed [C-1:0] px_q, py_q;
	logic [31:0]         pcolor_q;
	logic                pwe_q, plast_q;

	// Handshake
	logic in_ready, in_xfer, start_xfer, tick_xfer, emit;

	assign cw         = ucode_rom(step_q);
	assign in_ready   = cw.accept && (!out_valid_q || out_ch.ready);
	assign in_xfer    = in_ch.valid && in_ready;
	assign start_xfer = in_xfer && !in_ch.mode;
	assign tick_xfer  = in_xfer && in_ch.mode;
	assign emit       = tick_xfer && line_active_q;

	assign in_ch.ready         = in_ready;
	assign out_ch.valid        = out_valid_q;
	assign out_ch.pixel_x      = px_q;
	assign out_ch.pixel_y      = py_q;
	assign out_ch.pixel_color  = pcolor_q;
	assign out_ch.write_enable = pwe_q;
	assign out_ch.last_pixel   = plast_q;

	// Next step: jump to the control word's target when its condition holds,
	// otherwise advance.
	always_comb begin
		case (cw.jc)
			JC_NEVER:    take_jump = 1'b0;
			JC_ALWAYS:   take_jump = 1'b1;
			JC_NO_START: take_jump = !start_xfer;
			JC_DIV_BUSY: take_jump = (div_cnt_q != CNT_BITS'(1));
			default:     take_jump = 1'b1;
		endcase
		step_d = take_jump ? cw.target : step_t'(step_q + 1'b1);
	end

	// Setup: major axis choice and endpoint ordering.
	logic signed [C:0]   dx, dy, dmaj, dmin;
	logic        [C:0]   adx, ady;
	logic                sel_x, swap;
	logic signed [C-1:0] ma0, ma1, mi0, mi1;
	logic signed [C-1:0] ma_lo, ma_hi, mi_lo, mi_hi;

	always_comb begin
		dx    = {x1_q[C-1], x1_q} - {x0_q[C-1], x0_q};
		dy    = {y1_q[C-1], y1_q} - {y0_q[C-1], y0_q};
		adx   = dx[C] ? -dx : dx;
		ady   = dy[C] ? -dy : dy;
		sel_x = (adx >= ady);
		ma0   = sel_x ? x0_q : y0_q;
		ma1   = sel_x ? x1_q : y1_q;
		mi0   = sel_x ? y0_q : x0_q;
		mi1   = sel_x ? y1_q : x1_q;
		swap  = (ma1 < ma0);
		ma_lo = swap ? ma1 : ma0;
		ma_hi = swap ? ma0 : ma1;
		mi_lo = swap ? mi1 : mi0;
		mi_hi = swap ? mi0 : mi1;
		dmaj  = {ma_hi[C-1], ma_hi} - {ma_lo[C-1], ma_lo};
		dmin  = {mi_hi[C-1], mi_hi} - {mi_lo[C-1], mi_lo};
	end

	// Divider: one restoring quotient bit per step. The minor delta never
	// exceeds the major delta, so the magnitude fits COORD_BITS bits.
	logic [C:0] abs_min, trial, trial_sub;
	logic       q_bit;
	logic [F:0] quot;
	logic signed [SLP_BITS-1:0] slope_pos;

	always_comb begin
		abs_min   = dmin_q[C] ? -dmin_q : dmin_q;
		trial     = {rem_q, dvd_q[DVD_BITS-1]};
		trial_sub = trial - {1'b0, divisor_q};
		q_bit     = (trial >= {1'b0, divisor_q});
		quot      = dvd_q[F:0];
		slope_pos = {1'b0, quot};
	end

	// Pixel: minor coordinate by arithmetic shift, clip against the rectangle.
	logic signed [C:0]   minor_int, pix_x, pix_y;
	logic signed [C+1:0] right_e, bottom_e, left_e, top_e, xe, ye;
	logic                in_clip, last;

	always_comb begin
		minor_int = minor_pos_q[POS_BITS-1:F];
		pix_x     = major_is_x_q ? {major_pos_q[C-1], major_pos_q} : minor_int;
		pix_y     = major_is_x_q ? minor_int : {major_pos_q[C-1], major_pos_q};
		xe        = {pix_x[C], pix_x};
		ye        = {pix_y[C], pix_y};
		left_e    = {{2{clip_left_q[C-1]}}, clip_left_q};
		top_e     = {{2{clip_top_q[C-1]}}, clip_top_q};
		right_e   = left_e + {2'b00, clip_width_q};
		bottom_e  = top_e + {2'b00, clip_height_q};
		in_clip   = (xe >= left_e) && (xe < right_e) && (ye >= top_e) && (ye < bottom_e);
		last      = (major_pos_q >= major_end_q);
	end

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_enable_q <= 1'b0;
			clip_left_q   <= '0;
			clip_top_q    <= '0;
			clip_width_q  <= '0;
			clip_height_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CLIP_ENABLE: clip_enable_q <= cfg_data[0];
				CFG_CLIP_LEFT:   clip_left_q   <= cfg_data;
				CFG_CLIP_TOP:    clip_top_q    <= cfg_data;
				CFG_CLIP_WIDTH:  clip_width_q  <= cfg_data;
				CFG_CLIP_HEIGHT: clip_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control state: step counter, line activity, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q        <= STEP_WAIT;
			line_active_q <= 1'b0;
			out_valid_q   <= 1'b0;
			div_cnt_q     <= '0;
		end else begin
			step_q <= step_d;
			// a start replaces any line in progress; the final pixel ends it
			if (start_xfer) begin
				line_active_q <= 1'b1;
			end else if (emit && last) begin
				line_active_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cw.div_init) begin
				div_cnt_q <= CNT_BITS'(DVD_BITS);
			end else if (cw.div_step) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start_xfer) begin
			x0_q    <= in_ch.start_x;
			y0_q    <= in_ch.start_y;
			x1_q    <= in_ch.end_x;
			y1_q    <= in_ch.end_y;
			color_q <= in_ch.line_color;
		end
		if (cw.setup) begin
			major_is_x_q <= sel_x;
			major_pos_q  <= ma_lo;
			major_end_q  <= ma_hi;
			minor_pos_q  <= {mi_lo[C-1], mi_lo, {F{1'b0}}};
			dmin_q       <= dmin;
			divisor_q    <= dmaj[C-1:0];
		end
		if (cw.div_init) begin
			rem_q <= '0;
			dvd_q <= {abs_min[C-1:0], {F{1'b0}}};
		end
		if (cw.div_step) begin
			rem_q <= q_bit ? trial_sub[C-1:0] : trial[C-1:0];
			dvd_q <= {dvd_q[DVD_BITS-2:0], q_bit};
		end
		// truncate toward zero: divide magnitudes, then apply the sign
		if (cw.div_end) begin
			if (divisor_q == '0) begin
				minor_slope_q <= '0;
			end else if (dmin_q[C]) begin
				minor_slope_q <= -slope_pos;
			end else begin
				minor_slope_q <= slope_pos;
			end
		end
		if (emit) begin
			px_q     <= pix_x[C-1:0];
			py_q     <= pix_y[C-1:0];
			pcolor_q <= color_q;
			pwe_q    <= !clip_enable_q || in_clip;
			plast_q  <= last;
			// advance the DDA unless this was the final pixel
			if (!last) begin
				major_pos_q <= major_pos_q + 1'b1;
				minor_pos_q <= minor_pos_q + {{(POS_BITS-SLP_BITS){minor_slope_q[SLP_BITS-1]}},
					minor_slope_q};
			end
		end
	end

endmodule

// ===== bench/fixed_point_line_rasterizer_clipped_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the clipped fixed-point DDA line rasterizer.
// Depends on flrc_pkg, the channel interfaces in flrc_ifs.sv and the top level.
module fixed_point_line_rasterizer_clipped_unit_tb;

	import flrc_pkg::*;

	localparam int COORD_BITS = COORD_BITS_DEF;
	localparam int FRAC_BITS  = FRAC_BITS_DEF;

	// A start holds the input off for the slope divider; wait a bit longer than that
	// before touching the clip registers or ending the run.
	localparam int SETTLE_CYCLES = COORD_BITS + FRAC_BITS + 8;
	localparam int RANDOM_ITEMS  = 2000;
	localparam int PHASES        = 7;
	localparam int MAX_TICKS     = 48;
	localparam int unsigned CYCLE_LIMIT = 1_200_000;

	typedef enum logic {
		LINE_START = 1'b0,
		LINE_TICK  = 1'b1
	} line_op_e;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		line_op_e    mode;
		coord_t      sx;
		coord_t      sy;
		coord_t      ex;
		coord_t      ey;
		logic [31:0] color;
	} line_cmd_t;

	typedef struct packed {
		coord_t      x;
		coord_t      y;
		logic [31:0] color;
		logic        we;
		logic        last;
	} pixel_t;

	// One row of the directed script; typed rows carry a hand-written pixel.
	typedef struct {
		line_cmd_t cmd;
		bit        typed;
		pixel_t    want;
	} script_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [COORD_BITS-1:0]   cfg_data;

	flrc_in_if  #(.COORD_BITS(COORD_BITS)) in_ch ();
	flrc_out_if #(.COORD_BITS(COORD_BITS)) out_ch ();

	fixed_point_line_rasterizer_clipped_unit #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// ---------------------------------------------------------------
	// Line stepper state and clip window, mirrored at the block widths
	// ---------------------------------------------------------------
	bit                                 line_on    = 1'b0;
	bit                                 major_x    = 1'b0;
	bit signed [COORD_BITS-1:0]         major_pos  = '0;
	bit signed [COORD_BITS-1:0]         major_stop = '0;
	bit signed [COORD_BITS+FRAC_BITS:0] minor_acc  = '0;
	bit signed [FRAC_BITS+1:0]          minor_inc  = '0;
	bit        [31:0]                   line_rgba  = '0;

	bit                         clip_on = 1'b0;
	bit signed [COORD_BITS-1:0] clip_x0 = '0;
	bit signed [COORD_BITS-1:0] clip_y0 = '0;
	bit        [COORD_BITS-1:0] clip_w  = '0;
	bit        [COORD_BITS-1:0] clip_h  = '0;

	pixel_t pixel_q[$];    // pixels owed by the block, oldest first
	int     error_count = 0;
	bit     send_calm   = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Advance the line stepper by one accepted transfer; return 1 when a pixel is due.
	function automatic bit raster_step(input line_cmd_t c, output pixel_t px);
		int x0, y0, x1, y1, adx, ady;
		int ma0, ma1, mi0, mi1, swap_tmp;
		int minor, px_i, py_i, left, top;
		bit hit;
		px = '0;
		if (c.mode == LINE_START) begin
			x0 = c.sx;
			y0 = c.sy;
			x1 = c.ex;
			y1 = c.ey;
			adx = (x1 - x0) < 0 ? x0 - x1 : x1 - x0;
			ady = (y1 - y0) < 0 ? y0 - y1 : y1 - y0;
			// Ties go to x as the major axis.
			major_x = adx >= ady;
			if (major_x) begin
				ma0 = x0; ma1 = x1; mi0 = y0; mi1 = y1;
			end else begin
				ma0 = y0; ma1 = y1; mi0 = x0; mi1 = x1;
			end
			// Walk the major axis upward: swap the endpoints if needed.
			if (ma1 < ma0) begin
				swap_tmp = ma0; ma0 = ma1; ma1 = swap_tmp;
				swap_tmp = mi0; mi0 = mi1; mi1 = swap_tmp;
			end
			major_pos  = coord_t'(ma0);
			major_stop = coord_t'(ma1);
			minor_acc  = (COORD_BITS+FRAC_BITS+1)'(mi0 * (1 << FRAC_BITS));
			// Integer division truncates toward zero, like the hardware divider.
			minor_inc  = (FRAC_BITS+2)'((ma1 == ma0) ? 0 :
				((mi1 - mi0) * (1 << FRAC_BITS)) / (ma1 - ma0));
			line_rgba  = c.color;
			line_on    = 1'b1;
			return 1'b0;
		end
		if (!line_on)
			return 1'b0;
		minor = minor_acc >>> FRAC_BITS;
		px_i  = major_x ? int'(major_pos) : minor;
		py_i  = major_x ? minor : int'(major_pos);
		left  = clip_x0;
		top   = clip_y0;
		// Right and bottom edges are exclusive and computed without wrapping.
		hit = px_i >= left && px_i < left + int'(clip_w) &&
			py_i >= top && py_i < top + int'(clip_h);
		px.x     = coord_t'(px_i);
		px.y     = coord_t'(py_i);
		px.color = line_rgba;
		px.we    = !clip_on || hit;
		px.last  = major_pos >= major_stop;
		if (px.last) begin
			line_on = 1'b0;
		end else begin
			major_pos = coord_t'(major_pos + 1);
			minor_acc = minor_acc + minor_inc;
		end
		return 1'b1;
	endfunction

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic script_row_t start_row(int sx, int sy, int ex, int ey,
		logic [31:0] color);
		script_row_t row;
		row.cmd   = '{LINE_START, coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey),
			color};
		row.typed = 1'b0;
		row.want  = '0;
		return row;
	endfunction

	// Ticks carry random filler in the endpoint fields; the block ignores it.
	function automatic line_cmd_t random_tick();
		line_cmd_t c;
		c = '{LINE_TICK, coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom), coord_t'($urandom), $urandom};
		return c;
	endfunction

	function automatic script_row_t tick_row();
		script_row_t row;
		row.cmd   = random_tick();
		row.typed = 1'b0;
		row.want  = '0;
		return row;
	endfunction

	function automatic script_row_t tick_want(int x, int y, logic [31:0] color,
		bit we, bit last);
		script_row_t row;
		row       = tick_row();
		row.typed = 1'b1;
		row.want  = '{coord_t'(x), coord_t'(y), color, we, last};
		return row;
	endfunction

	function automatic coord_t clamp_coord(int v);
		if (v > 2047)
			return 2047;
		if (v < -2048)
			return -2048;
		return coord_t'(v);
	endfunction

	// Endpoints for a random line: mostly short lines around the clip edges or the
	// coordinate rails, some long ones, and a few with every endpoint on a rail.
	function automatic line_cmd_t random_line();
		line_cmd_t c;
		int sel, span, cx, cy;
		sel   = $urandom_range(0, 99);
		c     = random_tick();
		c.mode = LINE_START;
		if (sel < 90) begin
			span = (sel < 70) ? 12 : 100;
			case ($urandom_range(0, 3))
				0: begin
					cx = clip_x0;
					cy = clip_y0;
				end
				1: begin
					cx = int'(clip_x0) + int'(clip_w);
					cy = int'(clip_y0) + int'(clip_h);
				end
				2: begin
					cx = $urandom_range(0, 1) ? 2047 : -2048;
					cy = $urandom_range(0, 1) ? 2047 : -2048;
				end
				default: begin
					cx = int'(coord_t'($urandom));
					cy = int'(coord_t'($urandom));
				end
			endcase
			c.sx = clamp_coord(cx + int'($urandom_range(0, 2 * span)) - span);
			c.sy = clamp_coord(cy + int'($urandom_range(0, 2 * span)) - span);
			c.ex = clamp_coord(cx + int'($urandom_range(0, 2 * span)) - span);
			c.ey = clamp_coord(cy + int'($urandom_range(0, 2 * span)) - span);
		end else if (sel >= 96) begin
			c.sx = coord_t'($urandom_range(0, 1) ? 2047 : -2048);
			c.sy = coord_t'($urandom_range(0, 1) ? 2047 : -2048);
			c.ex = coord_t'($urandom_range(0, 1) ? 2047 : -2048);
			c.ey = coord_t'($urandom_range(0, 1) ? 2047 : -2048);
		end
		return c;
	endfunction

	// Present one item after a random gap (none while send_calm is set), hold it until the transfer, then
	// run it through the stepper and queue whatever pixel it owes.
	task automatic send_cmd(input line_cmd_t c, input bit typed, input pixel_t want);
		int     gap;
		bit     due;
		pixel_t px;
		gap = send_calm ? 0 : idle_len();
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.mode       = c.mode;
		in_ch.start_x    = c.sx;
		in_ch.start_y    = c.sy;
		in_ch.end_x      = c.ex;
		in_ch.end_y      = c.ey;
		in_ch.line_color = c.color;
		in_ch.valid      = 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		due = raster_step(c, px);
		if (typed)
			px = want;
		if (due)
			pixel_q.push_back(px);
	endtask

	// Drop valid, let every owed pixel drain, then give the divider time to finish.
	task automatic settle();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input int data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data[COORD_BITS-1:0];
		@(negedge clk);
		cfg_we    = 1'b0;
		case (idx)
			CFG_CLIP_ENABLE: clip_on = data[0];
			CFG_CLIP_LEFT:   clip_x0 = data[COORD_BITS-1:0];
			CFG_CLIP_TOP:    clip_y0 = data[COORD_BITS-1:0];
			CFG_CLIP_WIDTH:  clip_w  = data[COORD_BITS-1:0];
			CFG_CLIP_HEIGHT: clip_h  = data[COORD_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_clip(input bit en, input int left, input int top,
		input int width, input int height);
		cfg_write(CFG_CLIP_ENABLE, en);
		cfg_write(CFG_CLIP_LEFT, left);
		cfg_write(CFG_CLIP_TOP, top);
		cfg_write(CFG_CLIP_WIDTH, width);
		cfg_write(CFG_CLIP_HEIGHT, height);
	endtask

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	// ---------------------------------------------------------------
	// Pixel sink: random stalls, with calm stretches where ready stays high
	// ---------------------------------------------------------------
	initial begin : pixel_sink
		int hold;
		int cyc;
		bit calm;
		hold = 0;
		cyc  = 0;
		calm = 1'b0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 128 == 0)
				calm = ($urandom_range(0, 2) == 0);
			if (hold > 0) begin
				out_ch.ready = 1'b0;
				hold--;
			end else begin
				out_ch.ready = 1'b1;
				if (!calm)
					hold = idle_len();
			end
		end
	end

	// Compare each pixel transfer, field by field, with the oldest owed pixel.
	always @(posedge clk) begin : pixel_check
		pixel_t want;
		if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pixel_q.size() == 0) begin
				report_mismatch($sformatf("unexpected pixel x=%0d y=%0d color=%h we=%b last=%b",
					out_ch.pixel_x, out_ch.pixel_y, out_ch.pixel_color,
					out_ch.write_enable, out_ch.last_pixel));
			end else begin
				want = pixel_q.pop_front();
				if (out_ch.pixel_x !== want.x || out_ch.pixel_y !== want.y ||
					out_ch.pixel_color !== want.color ||
					out_ch.write_enable !== want.we ||
					out_ch.last_pixel !== want.last) begin
					report_mismatch({
						$sformatf("pixel want x=%0d y=%0d color=%h we=%b last=%b, ",
							want.x, want.y, want.color, want.we, want.last),
						$sformatf("got x=%0d y=%0d color=%h we=%b last=%b",
							out_ch.pixel_x, out_ch.pixel_y, out_ch.pixel_color,
							out_ch.write_enable, out_ch.last_pixel)});
				end
			end
		end
	end

	// Hard stop in case a handshake never completes.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[fixed_point_line_rasterizer_clipped_unit] ERROR");
		$finish;
	end

	// ---------------------------------------------------------------
	// Stimulus: reset, directed script, then random phases per clip setting
	// ---------------------------------------------------------------
	initial begin : stimulus
		script_row_t script[$];
		line_cmd_t   c;
		int          sent;
		int          len;
		int          n;
		int          dx;
		int          dy;
		int          t;

		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = CFG_CLIP_ENABLE;
		cfg_data         = '0;
		in_ch.valid      = 1'b0;
		in_ch.mode       = LINE_START;
		in_ch.start_x    = '0;
		in_ch.start_y    = '0;
		in_ch.end_x      = '0;
		in_ch.end_y      = '0;
		in_ch.line_color = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Clipping is off after reset, so every typed pixel has write_enable set.
		script.push_back(tick_row());    // tick with no line: no pixel
		// Point lines on opposite corners of the coordinate range: one pixel, flagged last
		script.push_back(start_row(-2048, 2047, -2048, 2047, 32'hFFFF_FFFF));
		script.push_back(tick_want(-2048, 2047, 32'hFFFF_FFFF, 1'b1, 1'b1));
		script.push_back(tick_row());    // line finished: back to idle
		script.push_back(start_row(2047, -2048, 2047, -2048, 32'h0000_0000));
		script.push_back(tick_want(2047, -2048, 32'h0000_0000, 1'b1, 1'b1));
		// X-major line given right to left with a falling minor: negative truncated slope
		script.push_back(start_row(3, 3, 0, 5, 32'h1234_5678));
		repeat (4) script.push_back(tick_row());
		// Y-major line, cut short by a new start that replaces it
		script.push_back(start_row(-1, -1, 1, 4, 32'h00FF_00FF));
		repeat (3) script.push_back(tick_row());
		// Equal deltas pick x as major
		script.push_back(start_row(0, 0, 6, 6, 32'hA5A5_5A5A));
		repeat (7) script.push_back(tick_row());
		script.push_back(tick_row());
		foreach (script[i])
			send_cmd(script[i].cmd, script[i].typed, script[i].want);

		sent = 0;
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: apply_clip(1'b1, -2048, -2048, 4095, 4095);
				1: apply_clip(1'b1, 2047, 2047, 4095, 4095);
				2: apply_clip(1'b1, int'($urandom_range(0, 80)) - 40,
					int'($urandom_range(0, 80)) - 40, 0, $urandom_range(0, 4095));
				3: apply_clip(1'b1, int'($urandom_range(0, 80)) - 40,
					int'($urandom_range(0, 80)) - 40,
					$urandom_range(1, 60), $urandom_range(1, 60));
				4: apply_clip(1'b0, $urandom, $urandom, $urandom, $urandom);
				5: apply_clip(1'b1, 0, -2048, 1, 4095);
				default: apply_clip(1'b1, $urandom, $urandom, $urandom, $urandom);
			endcase
			while (sent < (p + 1) * RANDOM_ITEMS / PHASES) begin
				if ($urandom_range(0, 39) == 0)
					send_calm = !send_calm;
				if ($urandom_range(0, 99) < 12) begin
					// Noise: any mode with any field values
					c      = random_tick();
					c.mode = line_op_e'($urandom_range(0, 1));
					send_cmd(c, 1'b0, '0);
					sent++;
				end else begin
					c = random_line();
					send_cmd(c, 1'b0, '0);
					sent++;
					dx  = c.ex - c.sx;
					dy  = c.ey - c.sy;
					dx  = dx < 0 ? -dx : dx;
					dy  = dy < 0 ? -dy : dy;
					len = (dx >= dy ? dx : dy) + 1;
					// Mostly draw the whole line, sometimes stop early or tick past the end.
					t = $urandom_range(0, 99);
					if (t < 75)
						n = len + (($urandom_range(0, 3) == 0) ? 1 : 0);
					else if (t < 92)
						n = $urandom_range(0, len);
					else
						n = len + $urandom_range(1, 3);
					if (n > MAX_TICKS)
						n = $urandom_range(1, MAX_TICKS);
					repeat (n) begin
						send_cmd(random_tick(), 1'b0, '0);
						sent++;
					end
				end
			end
			// Close any line left open with a point line and its single tick.
			c      = random_tick();
			c.mode = LINE_START;
			c.ex   = c.sx;
			c.ey   = c.sy;
			send_cmd(c, 1'b0, '0);
			send_cmd(random_tick(), 1'b0, '0);
			sent += 2;
		end
		settle();

		if (error_count == 0)
			$display("[fixed_point_line_rasterizer_clipped_unit] OK");
		else
			$display("[fixed_point_line_rasterizer_clipped_unit] ERROR");
		$finish;
	end

endmodule
